// ----- rtl/core/afu_pkg.sv -----
// ----------------------------------------------------------------------------
// afu_pkg: shared types and constants of the activation function unit
// Data format, function codes, register indexes and the fixed-point
// constants used by the forward and gradient datapaths.
// ----------------------------------------------------------------------------
package afu_pkg;

	// Data format
	localparam int DATA_WIDTH    = 24;
	localparam int FRACTION_BITS = 16;

	// Wide working width: holds any product of two operands before saturation
	localparam int RES_W   = 2 * DATA_WIDTH + 2;
	// Multiplier operand A width (2*(1-y) needs two extra bits)
	localparam int MUL_A_W = DATA_WIDTH + 2;

	// Configuration port
	localparam int FUNC_CODE_W = 4;
	localparam int CFG_DATA_W  = FUNC_CODE_W;

	typedef enum logic [0:0] {
		REG_FUNCTION_CODE = 1'b0,
		REG_GRADIENT_MODE = 1'b1
	} cfg_reg_t;

	typedef enum logic [FUNC_CODE_W-1:0] {
		FN_LINEAR   = 4'd0,
		FN_RELU     = 4'd1,
		FN_RELU6    = 4'd2,
		FN_LEAKY    = 4'd3,
		FN_RELIE    = 4'd4,
		FN_RAMP     = 4'd5,
		FN_HARDTAN  = 4'd6,
		FN_PLSE     = 4'd7,
		FN_LHTAN    = 4'd8,
		FN_STAIR    = 4'd9,
		FN_LOGISTIC = 4'd10,
		FN_LOGGY    = 4'd11,
		FN_TANH     = 4'd12,
		FN_ELU      = 4'd13,
		FN_SELU     = 4'd14
	} func_code_t;

	// Code with no function in either mode
	localparam logic [FUNC_CODE_W-1:0] FN_CODE_NONE = 4'd15;

	// Fixed-point constants (all floored, all positive)
	localparam longint ONE_L = longint'(1) << FRACTION_BITS;

	localparam logic signed [RES_W-1:0] ONE_R        = RES_W'(ONE_L);
	localparam logic signed [RES_W-1:0] HALF_R       = RES_W'(ONE_L / 2);
	localparam logic signed [RES_W-1:0] FOUR_R       = RES_W'(ONE_L * 4);
	localparam logic signed [RES_W-1:0] SIX_R        = RES_W'(ONE_L * 6);
	localparam logic signed [RES_W-1:0] EIGHTH_R     = RES_W'(ONE_L / 8);
	localparam logic signed [RES_W-1:0] TENTH_R      = RES_W'(ONE_L / 10);
	localparam logic signed [RES_W-1:0] HUNDREDTH_R  = RES_W'(ONE_L / 100);
	localparam logic signed [RES_W-1:0] THOUSANDTH_R = RES_W'(ONE_L / 1000);
	localparam logic signed [RES_W-1:0] SELU_POS_R   = RES_W'((ONE_L * 10507) / 10000);
	localparam logic signed [RES_W-1:0] SELU_NEG_R   =
		RES_W'((ONE_L * 10507 * 16732) / 100000000);

	// Output range
	localparam logic signed [DATA_WIDTH-1:0] OUT_MAX_D = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [DATA_WIDTH-1:0] OUT_MIN_D = {1'b1, {(DATA_WIDTH-1){1'b0}}};
	localparam logic signed [RES_W-1:0]      OUT_MAX_R = RES_W'(OUT_MAX_D);
	localparam logic signed [RES_W-1:0]      OUT_MIN_R = RES_W'(OUT_MIN_D);

	// Constant divider: exact reciprocal multiply for magnitudes below 2^DIV_UW.
	// Shift is DIV_UW + ceil(log2(d)), reciprocal is ceil(2^shift / d).
	localparam int DIV_UW  = DATA_WIDTH + 2;
	localparam int RECIP_W = DIV_UW + 1;
	localparam int SH10    = DIV_UW + 4;
	localparam int SH100   = DIV_UW + 7;
	localparam int SH1000  = DIV_UW + 10;

	localparam logic [RECIP_W-1:0] RECIP10   = RECIP_W'(((64'd1 << SH10) + 64'd9) / 64'd10);
	localparam logic [RECIP_W-1:0] RECIP100  = RECIP_W'(((64'd1 << SH100) + 64'd99) / 64'd100);
	localparam logic [RECIP_W-1:0] RECIP1000 =
		RECIP_W'(((64'd1 << SH1000) + 64'd999) / 64'd1000);

	// Divisor minus one, used to turn floor of a negative into ceil of a magnitude
	localparam logic [DIV_UW-1:0] BIAS10   = DIV_UW'(9);
	localparam logic [DIV_UW-1:0] BIAS100  = DIV_UW'(99);
	localparam logic [DIV_UW-1:0] BIAS1000 = DIV_UW'(999);

	typedef enum logic [1:0] {
		DIV_BY_10,
		DIV_BY_100,
		DIV_BY_1000
	} div_sel_t;

endpackage

// ----- rtl/core/afu_cdiv.sv -----
// ----------------------------------------------------------------------------
// afu_cdiv: floor division by 10, 100 or 1000
// Signed floor quotient through one multiply by an exact reciprocal.
// ----------------------------------------------------------------------------
module afu_cdiv (
	input  logic signed [afu_pkg::DIV_UW-1:0] num,
	input  afu_pkg::div_sel_t                 sel,
	output logic signed [afu_pkg::DIV_UW-1:0] quo
);
	import afu_pkg::*;

	logic                              neg;
	logic signed [DIV_UW:0]            num_x;
	logic signed [DIV_UW:0]            mag_x;
	logic [DIV_UW-1:0]                 mag;
	logic [DIV_UW-1:0]                 bias;
	logic [RECIP_W-1:0]                recip;
	logic [DIV_UW+RECIP_W-1:0]         prod;
	logic [DIV_UW-1:0]                 q;

	// Per-divisor reciprocal and rounding bias
	always_comb begin
		unique case (sel)
			DIV_BY_10: begin
				recip = RECIP10;
				bias  = BIAS10;
			end
			DIV_BY_100: begin
				recip = RECIP100;
				bias  = BIAS100;
			end
			DIV_BY_1000: begin
				recip = RECIP1000;
				bias  = BIAS1000;
			end
			default: begin
				recip = '0;
				bias  = '0;
			end
		endcase
	end

	// floor(n/d) = -ceil(-n/d) for negative n
	assign neg   = num[DIV_UW-1];
	assign num_x = {num[DIV_UW-1], num};
	assign mag_x = neg ? (-num_x + $signed({1'b0, bias})) : num_x;
	assign mag   = mag_x[DIV_UW-1:0];
	assign prod  = mag * recip;

	always_comb begin
		unique case (sel)
			DIV_BY_10:   q = DIV_UW'(prod >> SH10);
			DIV_BY_100:  q = DIV_UW'(prod >> SH100);
			DIV_BY_1000: q = DIV_UW'(prod >> SH1000);
			default:     q = '0;
		endcase
	end

	assign quo = neg ? -$signed(q) : $signed(q);

endmodule

// ----- rtl/core/afu_fwd.sv -----
// ----------------------------------------------------------------------------
// afu_fwd: forward activation datapath
// Piecewise-linear activations, result in the wide working format.
// ----------------------------------------------------------------------------
module afu_fwd (
	input  logic signed [afu_pkg::DATA_WIDTH-1:0] x,
	input  afu_pkg::func_code_t                   code,
	output logic signed [afu_pkg::RES_W-1:0]      res
);
	import afu_pkg::*;

	logic signed [RES_W-1:0]  xw;
	logic signed [RES_W-1:0]  num_w;
	logic signed [RES_W-1:0]  qw;
	logic signed [RES_W-1:0]  stair;
	logic signed [DIV_UW-1:0] quo;
	div_sel_t                 sel;

	assign xw = RES_W'(x);

	// Divider operand and divisor per function
	always_comb begin
		unique case (code)
			FN_PLSE: begin
				num_w = (xw < -FOUR_R) ? (xw + FOUR_R) : (xw - FOUR_R);
				sel   = DIV_BY_100;
			end
			FN_LHTAN: begin
				num_w = (xw < 0) ? xw : (xw - ONE_R);
				sel   = DIV_BY_1000;
			end
			FN_RELIE: begin
				num_w = xw;
				sel   = DIV_BY_100;
			end
			default: begin
				num_w = xw;
				sel   = DIV_BY_10;
			end
		endcase
	end

	afu_cdiv u_cdiv (
		.num (DIV_UW'(num_w)),
		.sel (sel),
		.quo (quo)
	);

	assign qw = RES_W'(quo);

	// Stair: floor(x/2) as integer, plus the fraction when floor(x) is odd
	assign stair = ((xw >>> (FRACTION_BITS + 1)) <<< FRACTION_BITS)
		+ (x[FRACTION_BITS] ? RES_W'($signed({1'b0, x[FRACTION_BITS-1:0]})) : RES_W'(0));

	// Function select
	always_comb begin
		unique case (code)
			FN_LINEAR:  res = xw;
			FN_RELU:    res = (xw > 0) ? xw : '0;
			FN_RELU6:   res = (xw < 0) ? '0 : ((xw > SIX_R) ? SIX_R : xw);
			FN_LEAKY:   res = (xw > 0) ? xw : qw;
			FN_RELIE:   res = (xw > 0) ? xw : qw;
			FN_RAMP:    res = ((xw > 0) ? xw : RES_W'(0)) + qw;
			FN_HARDTAN: res = (xw < -ONE_R) ? -ONE_R : ((xw > ONE_R) ? ONE_R : xw);
			FN_PLSE: begin
				if (xw < -FOUR_R) begin
					res = qw;
				end else if (xw > FOUR_R) begin
					res = qw + ONE_R;
				end else begin
					res = (xw >>> 3) + HALF_R;
				end
			end
			FN_LHTAN: begin
				if (xw < 0) begin
					res = qw;
				end else if (xw > ONE_R) begin
					res = qw + ONE_R;
				end else begin
					res = xw;
				end
			end
			FN_STAIR:   res = stair;
			default:    res = '0;
		endcase
	end

endmodule

// ----- rtl/core/afu_grad.sv -----
// ----------------------------------------------------------------------------
// afu_grad: gradient datapath
// Derivatives in terms of the stored output; one shared fixed-point multiply.
// ----------------------------------------------------------------------------
module afu_grad (
	input  logic signed [afu_pkg::DATA_WIDTH-1:0] x,
	input  afu_pkg::func_code_t                   code,
	output logic signed [afu_pkg::RES_W-1:0]      res
);
	import afu_pkg::*;

	logic signed [RES_W-1:0]      xw;
	logic signed [RES_W-1:0]      y_w;
	logic signed [MUL_A_W-1:0]    mul_a;
	logic signed [DATA_WIDTH-1:0] mul_b;
	logic signed [RES_W-1:0]      prod;
	logic signed [RES_W-1:0]      prod_fx;
	logic                         frac_zero;

	assign xw        = RES_W'(x);
	assign y_w       = (xw + ONE_R) >>> 1;
	assign frac_zero = (x[FRACTION_BITS-1:0] == '0);

	// Multiplier operands: logistic (1-x)*x, loggy 2(1-y)*y, tanh x*x
	always_comb begin
		unique case (code)
			FN_LOGISTIC: begin
				mul_a = MUL_A_W'(ONE_R - xw);
				mul_b = x;
			end
			FN_LOGGY: begin
				mul_a = MUL_A_W'((ONE_R - y_w) <<< 1);
				mul_b = DATA_WIDTH'(y_w);
			end
			default: begin
				mul_a = MUL_A_W'(xw);
				mul_b = x;
			end
		endcase
	end

	// Arithmetic shift floors the exact product
	assign prod    = mul_a * mul_b;
	assign prod_fx = prod >>> FRACTION_BITS;

	always_comb begin
		unique case (code)
			FN_LINEAR:   res = ONE_R;
			FN_RELU:     res = (xw > 0) ? ONE_R : '0;
			FN_RELU6:    res = (xw > 0 && xw < SIX_R) ? ONE_R : '0;
			FN_LEAKY:    res = (xw > 0) ? ONE_R : TENTH_R;
			FN_RELIE:    res = (xw > 0) ? ONE_R : HUNDREDTH_R;
			FN_RAMP:     res = ((xw > 0) ? ONE_R : RES_W'(0)) + TENTH_R;
			FN_HARDTAN:  res = (xw > -ONE_R && xw < ONE_R) ? ONE_R : '0;
			FN_PLSE:     res = (xw < 0 || xw > ONE_R) ? HUNDREDTH_R : EIGHTH_R;
			FN_LHTAN:    res = (xw > 0 && xw < ONE_R) ? ONE_R : THOUSANDTH_R;
			FN_STAIR:    res = frac_zero ? '0 : ONE_R;
			FN_LOGISTIC: res = prod_fx;
			FN_LOGGY:    res = prod_fx;
			FN_TANH:     res = ONE_R - prod_fx;
			FN_ELU:      res = (xw >= 0) ? ONE_R : (xw + ONE_R);
			FN_SELU:     res = (xw >= 0) ? SELU_POS_R : (xw + SELU_NEG_R);
			default:     res = '0;
		endcase
	end

endmodule

// ----- rtl/core/activation_function_unit.sv -----
// ----------------------------------------------------------------------------
// activation_function_unit: fixed-point activation and gradient unit
// Element-wise activation / gradient with saturation, one value per transfer.
// ----------------------------------------------------------------------------
// Pipeline: an accepted input is held in the input register, then passes
//   through the datapath into the result register.
// Throughput: 1 item per cycle; the input stalls only when both registers are
//   full and the output is stalled.
// Reset: clears both valid bits; function_code resets to linear, forward mode.
// ----------------------------------------------------------------------------
module activation_function_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration
	input  logic                                  cfg_we,
	input  afu_pkg::cfg_reg_t                     cfg_index,
	input  logic [afu_pkg::CFG_DATA_W-1:0]        cfg_data,
	// input channel
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [afu_pkg::DATA_WIDTH-1:0] value_in,
	// output channel
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [afu_pkg::DATA_WIDTH-1:0] value_out,
	output logic                                  unsupported,
	output logic                                  saturated
);
	import afu_pkg::*;

	func_code_t                   function_code_q;
	logic                         gradient_mode_q;

	logic                         valid_s1;
	logic signed [DATA_WIDTH-1:0] value_s1;
	logic                         valid_s2;
	logic signed [DATA_WIDTH-1:0] value_s2;
	logic                         unsupported_s2;
	logic                         saturated_s2;

	logic                         load_s1;
	logic                         load_s2;
	logic signed [RES_W-1:0]      fwd_res;
	logic signed [RES_W-1:0]      grad_res;
	logic signed [RES_W-1:0]      raw_res;
	logic                         unsup_c;
	logic                         sat_hi;
	logic                         sat_lo;
	logic signed [DATA_WIDTH-1:0] value_c;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			function_code_q <= FN_LINEAR;
			gradient_mode_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FUNCTION_CODE: function_code_q <= func_code_t'(cfg_data);
				REG_GRADIENT_MODE: gradient_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Pipeline flow control
	assign load_s2  = !valid_s2 || !out_stall;
	assign load_s1  = !valid_s1 || load_s2;
	assign in_stall = !load_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			value_s1 <= value_in;
		end
	end

	// Datapaths
	afu_fwd u_fwd (
		.x    (value_s1),
		.code (function_code_q),
		.res  (fwd_res)
	);

	afu_grad u_grad (
		.x    (value_s1),
		.code (function_code_q),
		.res  (grad_res)
	);

	// Unsupported codes, result select and saturation
	assign unsup_c = (function_code_q == FN_CODE_NONE)
		|| (!gradient_mode_q && function_code_q >= FN_LOGISTIC);
	assign raw_res = gradient_mode_q ? grad_res : fwd_res;
	assign sat_hi  = raw_res > OUT_MAX_R;
	assign sat_lo  = raw_res < OUT_MIN_R;

	always_comb begin
		priority if (unsup_c) begin
			value_c = '0;
		end else if (sat_hi) begin
			value_c = OUT_MAX_D;
		end else if (sat_lo) begin
			value_c = OUT_MIN_D;
		end else begin
			value_c = DATA_WIDTH'(raw_res);
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2       <= 1'b0;
			unsupported_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2       <= valid_s1;
			unsupported_s2 <= unsup_c;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2 && valid_s1) begin
			value_s2     <= value_c;
			saturated_s2 <= !unsup_c && (sat_hi || sat_lo);
		end
	end

	assign out_valid   = valid_s2;
	assign value_out   = value_s2;
	assign unsupported = unsupported_s2;
	assign saturated   = saturated_s2;

	// Checks
	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && saturated_s2) |-> (value_s2 == OUT_MAX_D || value_s2 == OUT_MIN_D))
		else $error("saturated result not at a range limit");

	a_unsup_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && unsupported_s2) |-> (value_s2 == '0 && !saturated_s2))
		else $error("unsupported result not zero or flagged saturated");

	a_s1_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && load_s2) |=> valid_s2)
		else $error("item lost between input and result register");

	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> valid_s1)
		else $error("accepted item not held in input register");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2))
		else $error("input stalled with a free register");

endmodule
